/* src/tlef_pkg.sv */
// ----------------------------------------------------------------------------
// tlef_pkg: shared types and constants of the three-level event FIFO
// Queue sizing, command codes, register map and the request payload structs.
// ----------------------------------------------------------------------------
package tlef_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned LevelCount = 3;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned MemAddrW   = $clog2(LevelCount * QueueDepth);
  localparam int unsigned LevelW     = 2;
  localparam int unsigned CodeW      = 8;

  // Command codes
  localparam logic CmdPut = 1'b0;
  localparam logic CmdGet = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam int unsigned ApbAddrW   = 3;
  localparam logic        RegNoneIdx = 1'b0;
  localparam logic [CodeW-1:0] NoneCodeReset = 8'hFF;

  typedef struct packed {
    logic              command;
    logic [LevelW-1:0] level;
    logic [CodeW-1:0]  event_in;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]      event_out;
    logic                  event_valid;
    logic                  put_accepted;
    logic [LevelCount-1:0] pending_mask;
  } out_item_t;

endpackage

/* src/three_level_event_fifo.sv */
// ----------------------------------------------------------------------------
// three_level_event_fifo: three ring FIFOs of 8-bit event codes
// Put appends to a level's queue, get pops its oldest event; every result
// carries the pending mask of all levels after the request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  cfg     | input     | APB psel/penable/pready  | none_code at word 0
//
//  One request per cycle is accepted while in_stall_o is low; its result passes
//  through the event memory read stage, then a three-entry output queue.
//  Reset clears all pointers and counts and sets none_code to 0xFF; the event
//  memory itself is not cleared and needs no clearing pass.
//  in_stall_o rises only when the output queue and read stage hold three
//  results, so the input keeps moving while one result waits at the output.
module three_level_event_fifo
  import tlef_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef struct packed {
    logic                  event_valid;
    logic                  put_accepted;
    logic [LevelCount-1:0] pending_mask;
  } s1_flags_t;

  // Configuration register
  logic [CodeW-1:0] none_code_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      none_code_q <= NoneCodeReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegNoneIdx)) begin
      none_code_q <= pwdata[CodeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegNoneIdx) begin
      prdata = {{(32-CodeW){1'b0}}, none_code_q};
    end
  end

  // Queue state
  logic [IdxW-1:0] head_q [LevelCount];
  logic [IdxW-1:0] head_d [LevelCount];
  logic [IdxW-1:0] tail_q [LevelCount];
  logic [IdxW-1:0] tail_d [LevelCount];
  logic [CntW-1:0] fill_q [LevelCount];
  logic [CntW-1:0] fill_d [LevelCount];

  logic [CodeW-1:0] event_store_q [LevelCount*QueueDepth];
  logic [CodeW-1:0] rd_q;

  logic              in_acc;
  logic              lv_ok;
  logic [LevelW-1:0] lvl;
  logic              do_put;
  logic              do_get;
  logic [MemAddrW-1:0] wr_addr;
  logic [MemAddrW-1:0] rd_addr;
  logic [LevelCount-1:0] mask_d;

  logic      s1_valid_q;
  s1_flags_t s1_q;

  // Output queue
  out_item_t oq_q [3];
  logic [1:0] oq_cnt_q;
  logic [1:0] oq_cnt_d;
  logic [1:0] oq_wr_q;
  logic [1:0] oq_rd_q;
  logic       oq_push;
  logic       oq_pop;
  out_item_t  oq_in;

  assign in_stall_o = ({1'b0, oq_cnt_q} + {2'b00, s1_valid_q}) > 3'd2;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the request against the selected level
  assign lv_ok  = in_data_i.level < LevelW'(LevelCount);
  assign lvl    = lv_ok ? in_data_i.level : '0;
  assign do_put = in_acc && lv_ok && (in_data_i.command == CmdPut) &&
                  (fill_q[lvl] != CntW'(QueueDepth));
  assign do_get = in_acc && lv_ok && (in_data_i.command == CmdGet) &&
                  (fill_q[lvl] != '0);

  assign wr_addr = MemAddrW'(lvl) * MemAddrW'(QueueDepth) + MemAddrW'(tail_q[lvl]);
  assign rd_addr = MemAddrW'(lvl) * MemAddrW'(QueueDepth) + MemAddrW'(head_q[lvl]);

  // Advance pointers and counts
  always_comb begin
    for (int i = 0; i < LevelCount; i++) begin
      head_d[i] = head_q[i];
      tail_d[i] = tail_q[i];
      fill_d[i] = fill_q[i];
    end
    if (do_put) begin
      tail_d[lvl] = (tail_q[lvl] == IdxW'(QueueDepth - 1)) ? '0 : tail_q[lvl] + 1'b1;
      fill_d[lvl] = fill_q[lvl] + 1'b1;
    end
    if (do_get) begin
      head_d[lvl] = (head_q[lvl] == IdxW'(QueueDepth - 1)) ? '0 : head_q[lvl] + 1'b1;
      fill_d[lvl] = fill_q[lvl] - 1'b1;
    end
    for (int i = 0; i < LevelCount; i++) begin
      mask_d[i] = fill_d[i] != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LevelCount; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LevelCount; i++) begin
        head_q[i] <= head_d[i];
        tail_q[i] <= tail_d[i];
        fill_q[i] <= fill_d[i];
      end
    end
  end

  // Event memory: write on put, registered read on get
  always_ff @(posedge clk_i) begin
    if (do_put) begin
      event_store_q[wr_addr] <= in_data_i.event_in;
    end
    if (do_get) begin
      rd_q <= event_store_q[rd_addr];
    end
  end

  // Read stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.event_valid  <= do_get;
      s1_q.put_accepted <= do_put;
      s1_q.pending_mask <= mask_d;
    end
  end

  // Build the result and push it into the output queue
  always_comb begin
    oq_in.event_out    = s1_q.event_valid ? rd_q : none_code_q;
    oq_in.event_valid  = s1_q.event_valid;
    oq_in.put_accepted = s1_q.put_accepted;
    oq_in.pending_mask = s1_q.pending_mask;
  end

  assign oq_push     = s1_valid_q;
  assign oq_pop      = out_valid_o && !out_stall_i;
  assign out_valid_o = oq_cnt_q != '0;
  assign out_data_o  = oq_q[oq_rd_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (!oq_push && oq_pop) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= '0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == 2'd2) ? 2'd0 : oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == 2'd2) ? 2'd0 : oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_in;
    end
  end

endmodule

/* src/tlef_checker.sv */
// ----------------------------------------------------------------------------
// tlef_checker: port-level checks of the three-level event FIFO
// Watches the request channels and result flags over time.
// ----------------------------------------------------------------------------
module tlef_checker
  import tlef_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result payload changed");

  // A result never reports both a pop and a stored put
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.event_valid && out_data_o.put_accepted))
    else $error("event_valid and put_accepted both set");

  // Stall no request on an empty output side
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while no result waits");

  // Clear results under reset
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result request visible during reset");

endmodule

bind three_level_event_fifo tlef_checker u_tlef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
